@@ hdl/top_p_token_sampler_assert.svh @@
// Assertion macros shared by the checker.
`ifndef TOP_P_TOKEN_SAMPLER_ASSERT_SVH
`define TOP_P_TOKEN_SAMPLER_ASSERT_SVH

// Clocked on clk, off while rst is high.
`define TPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked on clk, also checked across reset.
`define TPS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/tps_pkg.sv @@
package tps_pkg;

  localparam int MAX_VOCAB_DEF = 32768;
  localparam int PROB_W        = 25;
  localparam int TOKEN_W       = 15;
  localparam int TOP_P_W       = 25;
  localparam int SEED_W        = 64;
  localparam int COIN_W        = 24;
  localparam int CFG_IDX_W     = 2;

  localparam logic [PROB_W-1:0]  ONE_Q24     = 25'h100_0000;
  localparam logic [TOP_P_W-1:0] TOP_P_RESET = 25'd15099494;
  localparam logic [SEED_W-1:0]  SEED_RESET  = 64'd1;
  localparam logic [63:0]        RNG_MULT    = 64'h2545_F491_4F6C_DD1D;

  localparam int XS_A = 12;
  localparam int XS_B = 25;
  localparam int XS_C = 27;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_GREEDY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_P  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 2'd2;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

endpackage

@@ hdl/top_p_token_sampler.sv @@
// Top-p token sampler. Probabilities (Q1.24) stream in one per cycle while
// in_stall is low and are stored; the transfer with last_item set closes the
// set, after which in_stall stays high while one sequencer walks the stored set
// through a single shared 32x32 multiplier and memories with one read port
// each. Greedy mode scans for the largest entry; plain sampling draws a coin
// and walks the cumulative sum; nucleus sampling runs the cutoff filter, a
// merge sort of the k kept entries in ceil(log2 k) passes, then walks the
// sorted entries up to the cut, twice. Each pass of the merge sort and
// each cumulative walk is bound by the one read port of the index and
// probability memories.
// One result transfer follows each set; the next set may load while it waits.
module top_p_token_sampler import tps_pkg::*; #(
  parameter int MAX_VOCAB = MAX_VOCAB_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PROB_W-1:0]    prob,
  input  logic                 last_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [TOKEN_W-1:0]   token,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SEED_W-1:0]    cfg_data
);

  logic               greedy;
  logic [TOP_P_W-1:0] top_p;
  logic               cfg_we;
  logic               rng_adv;
  logic [SEED_W-1:0]  rng_word;
  mul_req_t           mul_req;
  logic [63:0]        mul_p;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      greedy <= 1'b0;
      top_p  <= TOP_P_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_GREEDY) begin
        greedy <= cfg_data[0];
      end
      if (cfg_index == CFG_TOP_P) begin
        top_p <= cfg_data[TOP_P_W-1:0];
      end
    end
  end

  tps_rng u_rng (
    .clk     (clk),
    .rst     (rst),
    .seed_we (cfg_we && (cfg_index == CFG_SEED)),
    .seed    (cfg_data),
    .adv     (rng_adv),
    .word    (rng_word)
  );

  tps_mul u_mul (
    .clk (clk),
    .req (mul_req),
    .p   (mul_p)
  );

  tps_core #(.MAX_VOCAB(MAX_VOCAB)) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .prob      (prob),
    .last_item (last_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .token     (token),
    .greedy    (greedy),
    .top_p     (top_p),
    .rng_adv   (rng_adv),
    .rng_word  (rng_word),
    .mul_req   (mul_req),
    .mul_p     (mul_p)
  );

endmodule

@@ hdl/tps_rng.sv @@
module tps_rng import tps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              seed_we,
  input  logic [SEED_W-1:0] seed,
  input  logic              adv,
  output logic [SEED_W-1:0] word
);

  logic [SEED_W-1:0] s1;
  logic [SEED_W-1:0] s2;
  logic [SEED_W-1:0] word_next;

  always_comb begin
    s1        = word ^ (word >> XS_A);
    s2        = s1 ^ (s1 << XS_B);
    word_next = s2 ^ (s2 >> XS_C);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word <= SEED_RESET;
    end else if (seed_we) begin
      word <= seed;
    end else if (adv) begin
      word <= word_next;
    end
  end

endmodule

@@ hdl/tps_mul.sv @@
module tps_mul import tps_pkg::*; (
  input  logic        clk,
  input  mul_req_t    req,
  output logic [63:0] p
);

  // 32x32 unsigned, product registered and available in the cycle after the operands
  always_ff @(posedge clk) begin
    p <= 64'(req.a) * 64'(req.b);
  end

endmodule

@@ hdl/tps_core.sv @@
module tps_core import tps_pkg::*; #(
  parameter int MAX_VOCAB = MAX_VOCAB_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PROB_W-1:0]  prob,
  input  logic               last_item,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [TOKEN_W-1:0] token,
  input  logic               greedy,
  input  logic [TOP_P_W-1:0] top_p,
  output logic               rng_adv,
  input  logic [SEED_W-1:0]  rng_word,
  output mul_req_t           mul_req,
  input  logic [63:0]        mul_p
);

  localparam int IW = $clog2(MAX_VOCAB);
  localparam int CW = $clog2(MAX_VOCAB + 1);
  localparam int SW = CW + PROB_W;
  localparam int RW = SW + 1;

  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_ARG_RD   = 5'd1;
  localparam logic [4:0] ST_ARG_CMP  = 5'd2;
  localparam logic [4:0] ST_COIN_ADV = 5'd3;
  localparam logic [4:0] ST_COIN_M0  = 5'd4;
  localparam logic [4:0] ST_COIN_M1  = 5'd5;
  localparam logic [4:0] ST_COIN_M2  = 5'd6;
  localparam logic [4:0] ST_COIN_SUM = 5'd7;
  localparam logic [4:0] ST_PL_RD    = 5'd8;
  localparam logic [4:0] ST_PL_ACC   = 5'd9;
  localparam logic [4:0] ST_F_RD     = 5'd10;
  localparam logic [4:0] ST_F_MUL    = 5'd11;
  localparam logic [4:0] ST_F_CMP    = 5'd12;
  localparam logic [4:0] ST_S_PASS   = 5'd13;
  localparam logic [4:0] ST_S_FET_I  = 5'd14;
  localparam logic [4:0] ST_S_FET_P  = 5'd15;
  localparam logic [4:0] ST_S_FET_D  = 5'd16;
  localparam logic [4:0] ST_S_CMP    = 5'd17;
  localparam logic [4:0] ST_CUT_RD_I = 5'd18;
  localparam logic [4:0] ST_CUT_RD_P = 5'd19;
  localparam logic [4:0] ST_CUT_ACC  = 5'd20;
  localparam logic [4:0] ST_R_M0     = 5'd21;
  localparam logic [4:0] ST_R_M1     = 5'd22;
  localparam logic [4:0] ST_R_SUM    = 5'd23;
  localparam logic [4:0] ST_SM_RD_I  = 5'd24;
  localparam logic [4:0] ST_SM_RD_P  = 5'd25;
  localparam logic [4:0] ST_SM_ACC   = 5'd26;
  localparam logic [4:0] ST_DONE     = 5'd27;

  logic [4:0]        state;

  // stores
  logic [PROB_W-1:0] pmem [MAX_VOCAB];
  logic [IW-1:0]     amem [MAX_VOCAB];
  logic [IW-1:0]     bmem [MAX_VOCAB];
  logic [PROB_W-1:0] p_rd;
  logic [IW-1:0]     a_rd;
  logic [IW-1:0]     b_rd;
  logic [IW-1:0]     src_rd;
  logic [IW-1:0]     p_ra;
  logic [IW-1:0]     x_ra;
  logic              x_re;
  logic              a_we;
  logic              b_we;
  logic [IW-1:0]     x_wa;
  logic [IW-1:0]     x_wd;

  // working registers
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     n;
  logic [CW-1:0]     i;
  logic [IW-1:0]     best;
  logic [PROB_W-1:0] best_p;
  logic [COIN_W-1:0] c;
  logic [31:0]       hi32;
  logic [SW-1:0]     cdf;
  logic [CW-1:0]     kept;
  logic [CW:0]       w;
  logic [CW+1:0]     lo;
  logic [CW-1:0]     pa;
  logic [CW-1:0]     pb;
  logic [CW-1:0]     ea;
  logic [CW-1:0]     eb;
  logic [CW-1:0]     o;
  logic              ha_v;
  logic              hb_v;
  logic [IW-1:0]     ha_idx;
  logic [IW-1:0]     hb_idx;
  logic [PROB_W-1:0] ha_p;
  logic [PROB_W-1:0] hb_p;
  logic              fside;
  logic              init;
  logic              sel;
  logic [SW-1:0]     cum;
  logic [CW-1:0]     last;
  logic [RW-1:0]     r;
  logic [IW-1:0]     tok;

  // combinational helpers
  logic              acc_in;
  logic              full;
  logic              out_free;
  logic              plain;
  logic [PROB_W-1:0] need;
  logic [SW-1:0]     sum;
  logic [31:0]       sum32;
  logic              keep;
  logic [CW-1:0]     kept_inc;
  logic              take_a;
  logic              take_b;
  logic [CW+1:0]     t_mid;
  logic [CW+1:0]     t_hi;
  logic [CW+1:0]     k_ext;

  assign in_stall = (state != ST_IDLE);
  assign acc_in   = in_valid && !in_stall;
  assign full     = (cnt == CW'(MAX_VOCAB));
  assign out_free = !out_valid || !out_stall;
  assign plain    = (top_p == '0) || top_p[TOP_P_W-1];
  assign need     = ONE_Q24 - top_p;
  assign src_rd   = sel ? b_rd : a_rd;
  assign sum      = cdf + SW'(p_rd);
  assign sum32    = hi32 + mul_p[31:0];
  assign keep     = (mul_p >= 64'(need));
  assign kept_inc = kept + CW'(keep);
  assign take_a   = ha_v && (!hb_v || (ha_p >= hb_p));
  assign take_b   = hb_v && !take_a;
  assign k_ext    = (CW+2)'(kept);
  assign t_mid    = ((lo + (CW+2)'(w)) < k_ext) ? lo + (CW+2)'(w) : k_ext;
  assign t_hi     = ((lo + (CW+2)'(w << 1)) < k_ext) ? lo + (CW+2)'(w << 1) : k_ext;
  assign rng_adv  = (state == ST_COIN_ADV);

  // memory addressing and multiplier operands
  always_comb begin
    p_ra      = i[IW-1:0];
    x_ra      = i[IW-1:0];
    x_re      = 1'b0;
    a_we      = 1'b0;
    b_we      = 1'b0;
    x_wa      = o[IW-1:0];
    x_wd      = take_a ? ha_idx : hb_idx;
    mul_req.a = '0;
    mul_req.b = '0;
    unique case (state)
      ST_COIN_M0: begin
        mul_req.a = rng_word[31:0];
        mul_req.b = RNG_MULT[31:0];
      end
      ST_COIN_M1: begin
        mul_req.a = rng_word[63:32];
        mul_req.b = RNG_MULT[31:0];
      end
      ST_COIN_M2: begin
        mul_req.a = rng_word[31:0];
        mul_req.b = RNG_MULT[63:32];
      end
      ST_F_MUL: begin
        mul_req.a = 32'(p_rd);
        mul_req.b = 32'(n - CW'(1));
      end
      ST_F_CMP: begin
        a_we = keep;
        x_wa = kept[IW-1:0];
        x_wd = i[IW-1:0];
      end
      ST_S_FET_I: begin
        x_re = 1'b1;
        x_ra = fside ? pb[IW-1:0] : pa[IW-1:0];
      end
      ST_S_FET_P, ST_CUT_RD_P, ST_SM_RD_P: begin
        p_ra = src_rd;
      end
      ST_S_CMP: begin
        // destination is the buffer not being read
        a_we = (take_a || take_b) && sel;
        b_we = (take_a || take_b) && !sel;
      end
      ST_CUT_RD_I, ST_SM_RD_I: begin
        x_re = 1'b1;
      end
      ST_R_M0: begin
        mul_req.a = 32'(c);
        mul_req.b = 32'(cum >> 24);
      end
      ST_R_M1: begin
        mul_req.a = 32'(c);
        mul_req.b = 32'(cum[23:0]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (acc_in && !full) begin
      pmem[cnt[IW-1:0]] <= prob;
    end
    p_rd <= pmem[p_ra];
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      amem[x_wa] <= x_wd;
    end
    if (x_re) begin
      a_rd <= amem[x_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      bmem[x_wa] <= x_wd;
    end
    if (x_re) begin
      b_rd <= bmem[x_ra];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (acc_in) begin
            if (last_item) begin
              n      <= full ? cnt : cnt + CW'(1);
              cnt    <= '0;
              i      <= '0;
              best   <= '0;
              best_p <= '0;
              state  <= greedy ? ST_ARG_RD : ST_COIN_ADV;
            end else if (!full) begin
              cnt <= cnt + CW'(1);
            end
          end
        end
        ST_ARG_RD: state <= ST_ARG_CMP;
        ST_ARG_CMP: begin
          if (p_rd > best_p) begin
            best   <= i[IW-1:0];
            best_p <= p_rd;
          end
          if (i == n - CW'(1)) begin
            tok   <= (p_rd > best_p) ? i[IW-1:0] : best;
            state <= ST_DONE;
          end else begin
            i     <= i + CW'(1);
            state <= ST_ARG_RD;
          end
        end
        ST_COIN_ADV: state <= ST_COIN_M0;
        ST_COIN_M0:  state <= ST_COIN_M1;
        ST_COIN_M1: begin
          hi32  <= mul_p[63:32];
          state <= ST_COIN_M2;
        end
        ST_COIN_M2: begin
          hi32  <= sum32;
          state <= ST_COIN_SUM;
        end
        ST_COIN_SUM: begin
          c     <= sum32[31:8];
          i     <= '0;
          cdf   <= '0;
          kept  <= '0;
          sel   <= 1'b0;
          state <= plain ? ST_PL_RD : ST_F_RD;
        end
        ST_PL_RD: state <= ST_PL_ACC;
        ST_PL_ACC: begin
          if ((SW'(c) < sum) || (i == n - CW'(1))) begin
            tok   <= i[IW-1:0];
            state <= ST_DONE;
          end else begin
            cdf   <= sum;
            i     <= i + CW'(1);
            state <= ST_PL_RD;
          end
        end
        ST_F_RD:  state <= ST_F_MUL;
        ST_F_MUL: state <= ST_F_CMP;
        ST_F_CMP: begin
          kept <= kept_inc;
          if (i == n - CW'(1)) begin
            if (kept_inc == '0) begin
              tok   <= '0;
              state <= ST_DONE;
            end else begin
              w     <= (CW+1)'(1);
              lo    <= '0;
              state <= ST_S_PASS;
            end
          end else begin
            i     <= i + CW'(1);
            state <= ST_F_RD;
          end
        end
        ST_S_PASS: begin
          if (w >= (CW+1)'(kept)) begin
            i     <= '0;
            cum   <= '0;
            last  <= kept - CW'(1);
            state <= ST_CUT_RD_I;
          end else if (lo >= k_ext) begin
            lo  <= '0;
            w   <= w << 1;
            sel <= !sel;
          end else begin
            pa    <= CW'(lo);
            pb    <= CW'(t_mid);
            o     <= CW'(lo);
            ea    <= CW'(t_mid);
            eb    <= CW'(t_hi);
            ha_v  <= 1'b0;
            hb_v  <= 1'b0;
            fside <= 1'b0;
            init  <= 1'b1;
            state <= ST_S_FET_I;
          end
        end
        ST_S_FET_I: state <= ST_S_FET_P;
        ST_S_FET_P: state <= ST_S_FET_D;
        ST_S_FET_D: begin
          if (fside) begin
            hb_v   <= 1'b1;
            hb_idx <= src_rd;
            hb_p   <= p_rd;
          end else begin
            ha_v   <= 1'b1;
            ha_idx <= src_rd;
            ha_p   <= p_rd;
          end
          // at segment start the right run is fetched after the left one
          if (init) begin
            init <= 1'b0;
            if (pb < eb) begin
              fside <= 1'b1;
              state <= ST_S_FET_I;
            end else begin
              state <= ST_S_CMP;
            end
          end else begin
            state <= ST_S_CMP;
          end
        end
        ST_S_CMP: begin
          if (take_a) begin
            o  <= o + CW'(1);
            pa <= pa + CW'(1);
            if (pa + CW'(1) < ea) begin
              fside <= 1'b0;
              state <= ST_S_FET_I;
            end else begin
              ha_v <= 1'b0;
            end
          end else if (take_b) begin
            o  <= o + CW'(1);
            pb <= pb + CW'(1);
            if (pb + CW'(1) < eb) begin
              fside <= 1'b1;
              state <= ST_S_FET_I;
            end else begin
              hb_v <= 1'b0;
            end
          end else begin
            lo    <= lo + (CW+2)'(w << 1);
            state <= ST_S_PASS;
          end
        end
        ST_CUT_RD_I: state <= ST_CUT_RD_P;
        ST_CUT_RD_P: state <= ST_CUT_ACC;
        ST_CUT_ACC: begin
          cum <= cum + SW'(p_rd);
          if ((cum + SW'(p_rd)) > SW'(top_p)) begin
            last  <= i;
            state <= ST_R_M0;
          end else if (i == kept - CW'(1)) begin
            state <= ST_R_M0;
          end else begin
            i     <= i + CW'(1);
            state <= ST_CUT_RD_I;
          end
        end
        ST_R_M0: state <= ST_R_M1;
        ST_R_M1: begin
          r     <= RW'(mul_p);
          state <= ST_R_SUM;
        end
        ST_R_SUM: begin
          r     <= r + RW'(mul_p >> 24);
          i     <= '0;
          cdf   <= '0;
          state <= ST_SM_RD_I;
        end
        ST_SM_RD_I: state <= ST_SM_RD_P;
        ST_SM_RD_P: state <= ST_SM_ACC;
        ST_SM_ACC: begin
          if ((r < RW'(sum)) || (i == last)) begin
            tok   <= src_rd;
            state <= ST_DONE;
          end else begin
            cdf   <= sum;
            i     <= i + CW'(1);
            state <= ST_SM_RD_I;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      token <= TOKEN_W'(tok);
    end
  end

endmodule

@@ hdl/tps_checker.sv @@
module tps_checker import tps_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               last_item,
  input logic               out_valid,
  input logic               out_stall,
  input logic [TOKEN_W-1:0] token
);

`include "top_p_token_sampler_assert.svh"

  `TPS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(token), "result changed while stalled")
  `TPS_ASSERT(a_busy_after_last, in_valid && !in_stall && last_item |=> in_stall, "not busy after set closed")
  `TPS_ASSERT(a_result_from_busy, $rose(out_valid) |-> $past(in_stall), "result without processing")
  `TPS_ASSERT_RST(a_reset_idle, rst |=> !out_valid && !in_stall, "reset did not idle the block")

endmodule

bind top_p_token_sampler tps_checker u_chk (.*);
